// ===== hw/rtl/mpsm_pkg.sv =====
// mpsm_pkg: shared constants, codes and record types of the string matcher
// used by every module in hw/rtl; no dependencies
package mpsm_pkg;

    localparam int NODES       = 1024;
    localparam int MAX_LEN     = 32;
    localparam int MAX_RESULTS = 32;
    localparam int SYM_W       = 16;
    localparam int ID_W        = 16;
    localparam int KIND_W      = 3;
    localparam int OP_W        = 2;

    localparam int NW  = $clog2(NODES);
    localparam int NCW = $clog2(NODES + 1);
    localparam int DW  = $clog2(MAX_LEN + 1);
    localparam int LNW = $clog2(MAX_LEN + 2);
    localparam int PBW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int RNW = $clog2(MAX_RESULTS + 1);

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_END   = 2'd1;
    localparam logic [OP_W-1:0] OP_SCAN  = 2'd2;
    localparam logic [OP_W-1:0] OP_START = 2'd3;

    localparam logic [KIND_W-1:0] KIND_MATCH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OK    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LONG  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SYM_W-1:0] sym;
        logic [ID_W-1:0]  id;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } t_res;

    typedef struct packed {
        logic [NW-1:0]    par;
        logic [SYM_W-1:0] sym;
        logic [DW-1:0]    dep;
    } t_goto;

    typedef struct packed {
        logic            vld;
        logic [ID_W-1:0] id;
    } t_nout;

endpackage

// ===== hw/rtl/multi_pattern_string_matcher.sv =====
// add and start items finish in dispatch; end pattern walks the existing prefix with child searches, then appends nodes
// scan symbol follows failure links until a child is found, then reports the ids on its output chain
// first scan after a new pattern first rebuilds links, one child search per failure step
// child searches read the trie memory one entry per cycle; one item at a time
// synchronous active-low reset empties both queues and the trie; no clearing pass
// multi_pattern_string_matcher: top level; depends on mpsm_pkg, mpsm_front, mpsm_engine, mpsm_outq
module multi_pattern_string_matcher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_action,
    input  logic [mpsm_pkg::SYM_W-1:0]  i_symbol,
    input  logic [mpsm_pkg::ID_W-1:0]   i_pattern_id,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mpsm_pkg::KIND_W-1:0] o_kind,
    output logic [mpsm_pkg::ID_W-1:0]   o_match_id,
    output logic                        o_last
);

    logic           cmd_valid, cmd_pop, res_push, res_full;
    mpsm_pkg::t_cmd cmd;
    mpsm_pkg::t_res res;

    mpsm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_symbol     (i_symbol),
        .i_pattern_id (i_pattern_id),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    mpsm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    mpsm_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_push),
        .i_res       (res),
        .o_full      (res_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_match_id  (o_match_id),
        .o_last      (o_last)
    );

`ifndef ASSERT_OFF
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != mpsm_pkg::KIND_MATCH |-> o_last)
        else $error("status result without last");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind <= mpsm_pkg::KIND_EMPTY)
        else $error("result kind out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("queues not empty after reset");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");
`endif

endmodule

// ===== hw/rtl/mpsm_front.sv =====
// mpsm_front: accepts input transfers, decodes them into commands and
// holds them in a two-entry queue for the engine; depends on mpsm_pkg
module mpsm_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_action,
    input  logic [mpsm_pkg::SYM_W-1:0] i_symbol,
    input  logic [mpsm_pkg::ID_W-1:0]  i_pattern_id,
    output logic                       o_cmd_valid,
    output mpsm_pkg::t_cmd             o_cmd,
    input  logic                       i_cmd_pop
);

    mpsm_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;
    mpsm_pkg::t_cmd cmd;

    always_comb begin
        cmd.sym = i_symbol;
        cmd.id  = i_pattern_id;
        case (i_action)
            mpsm_pkg::OP_ADD:   cmd.op = mpsm_pkg::OP_ADD;
            mpsm_pkg::OP_END:   cmd.op = mpsm_pkg::OP_END;
            mpsm_pkg::OP_SCAN:  cmd.op = mpsm_pkg::OP_SCAN;
            default:            cmd.op = mpsm_pkg::OP_START;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hw/rtl/mpsm_outq.sv =====
// mpsm_outq: two-entry result queue between the engine and the output port
// depends on mpsm_pkg
module mpsm_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  mpsm_pkg::t_res              i_res,
    output logic                        o_full,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mpsm_pkg::KIND_W-1:0] o_kind,
    output logic [mpsm_pkg::ID_W-1:0]   o_match_id,
    output logic                        o_last
);

    mpsm_pkg::t_res r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign o_full      = (r_cnt == 2'd2);
    assign push        = i_push && !o_full;
    assign o_out_valid = (r_cnt != 2'd0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_kind      = r_q[r_rp].kind;
    assign o_match_id  = r_q[r_rp].id;
    assign o_last      = r_q[r_rp].last;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hw/rtl/mpsm_engine.sv =====
// mpsm_engine: trie build, failure link rebuild and text scan sequencer
// owns the trie memories; depends on mpsm_pkg
module mpsm_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  mpsm_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_res_push,
    output mpsm_pkg::t_res o_res,
    input  logic           i_res_full
);

    localparam int NW  = mpsm_pkg::NW;
    localparam int NCW = mpsm_pkg::NCW;
    localparam int DW  = mpsm_pkg::DW;
    localparam int LNW = mpsm_pkg::LNW;
    localparam int PBW = mpsm_pkg::PBW;
    localparam int RNW = mpsm_pkg::RNW;
    localparam int SW  = mpsm_pkg::SYM_W;
    localparam int IW  = mpsm_pkg::ID_W;
    localparam int KW  = mpsm_pkg::KIND_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_CRD   = 5'd2;
    localparam logic [4:0] S_CKEY  = 5'd3;
    localparam logic [4:0] S_CCHK  = 5'd4;
    localparam logic [4:0] S_CFULL = 5'd5;
    localparam logic [4:0] S_NRD   = 5'd6;
    localparam logic [4:0] S_NWR   = 5'd7;
    localparam logic [4:0] S_CFIN  = 5'd8;
    localparam logic [4:0] S_RES   = 5'd9;
    localparam logic [4:0] S_SRCH  = 5'd10;
    localparam logic [4:0] S_RBI   = 5'd11;
    localparam logic [4:0] S_RBRD  = 5'd12;
    localparam logic [4:0] S_RBCHK = 5'd13;
    localparam logic [4:0] S_RBF   = 5'd14;
    localparam logic [4:0] S_RBS   = 5'd15;
    localparam logic [4:0] S_SCST  = 5'd16;
    localparam logic [4:0] S_SCS   = 5'd17;
    localparam logic [4:0] S_SCF   = 5'd18;
    localparam logic [4:0] S_SCO   = 5'd19;
    localparam logic [4:0] S_SCOQ  = 5'd20;
    localparam logic [4:0] S_SCEND = 5'd21;

    // memories
    mpsm_pkg::t_goto goto_mem [mpsm_pkg::NODES];
    logic [NW-1:0]   fail_mem [mpsm_pkg::NODES];
    mpsm_pkg::t_nout out_mem  [mpsm_pkg::NODES];
    logic [SW-1:0]   pbuf_mem [mpsm_pkg::MAX_LEN];

    mpsm_pkg::t_goto goto_q, goto_wd;
    logic [NW-1:0]   fail_q, fail_wd;
    mpsm_pkg::t_nout out_q, out_wd;
    logic [SW-1:0]   pbuf_q;

    logic            goto_re, goto_we, fail_re, fail_we, out_re, out_we, pbuf_re, pbuf_we;
    logic [NW-1:0]   goto_ra, goto_wa, fail_ra, fail_wa, out_ra, out_wa;
    logic [PBW-1:0]  pbuf_ra, pbuf_wa;

    logic [4:0]      r_st, n_st, r_ret, n_ret;
    mpsm_pkg::t_cmd  r_cmd, n_cmd;
    logic [LNW-1:0]  r_len, n_len, r_plen, n_plen, r_i, n_i;
    logic [NW-1:0]   r_cur, n_cur, r_scan, n_scan, r_kpar, n_kpar;
    logic [NCW-1:0]  r_nc, n_nc, r_sk, n_sk, r_rv, n_rv;
    logic            r_stale, n_stale, r_sv, n_sv, r_pend, n_pend;
    logic [KW-1:0]   r_kind, n_kind;
    logic [SW-1:0]   r_ksym, n_ksym;
    logic [NW-1:0]   r_sidx, n_sidx, r_child, n_child, r_f, n_f, r_cv, n_cv;
    logic [DW-1:0]   r_d, n_d;
    logic [RNW-1:0]  r_n, n_n;
    logic [IW-1:0]   r_pid, n_pid;

    logic [NCW+LNW:0] need_sum;
    logic [LNW-1:0]   i_inc;
    logic [NW-1:0]    scan_base;
    logic             hit;

    always_ff @(posedge i_clk) begin
        if (goto_we) begin
            goto_mem[goto_wa] <= goto_wd;
        end
        if (goto_re) begin
            goto_q <= goto_mem[goto_ra];
        end
        if (fail_we) begin
            fail_mem[fail_wa] <= fail_wd;
        end
        if (fail_re) begin
            fail_q <= fail_mem[fail_ra];
        end
        if (out_we) begin
            out_mem[out_wa] <= out_wd;
        end
        if (out_re) begin
            out_q <= out_mem[out_ra];
        end
        if (pbuf_we) begin
            pbuf_mem[pbuf_wa] <= r_cmd.sym;
        end
        if (pbuf_re) begin
            pbuf_q <= pbuf_mem[pbuf_ra];
        end
    end

    assign need_sum  = (NCW+LNW+1)'(r_nc) + (NCW+LNW+1)'(r_plen - r_i);
    assign i_inc     = r_i + 1'b1;
    assign scan_base = ({1'b0, r_scan} >= r_nc) ? '0 : r_scan;
    assign hit       = r_sv && (goto_q.par == r_kpar) && (goto_q.sym == r_ksym);

    always_comb begin
        n_st = r_st;     n_ret = r_ret;   n_cmd = r_cmd;   n_len = r_len;
        n_plen = r_plen; n_i = r_i;       n_cur = r_cur;   n_scan = r_scan;
        n_kpar = r_kpar; n_nc = r_nc;     n_sk = r_sk;     n_rv = r_rv;
        n_stale = r_stale; n_sv = r_sv;   n_pend = r_pend; n_kind = r_kind;
        n_ksym = r_ksym; n_sidx = r_sidx; n_child = r_child; n_f = r_f;
        n_cv = r_cv;     n_d = r_d;       n_n = r_n;       n_pid = r_pid;

        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{kind: mpsm_pkg::KIND_MATCH, id: r_pid, last: 1'b0};

        goto_re = 1'b0; goto_ra = r_sk[NW-1:0];
        goto_we = 1'b0; goto_wa = r_nc[NW-1:0];
        goto_wd = '{par: r_cur, sym: pbuf_q, dep: DW'(i_inc)};
        fail_re = 1'b0; fail_ra = r_scan;
        fail_we = 1'b0; fail_wa = r_rv[NW-1:0]; fail_wd = '0;
        out_re  = 1'b0; out_ra = r_cv;
        out_we  = 1'b0; out_wa = r_nc[NW-1:0]; out_wd = '0;
        pbuf_re = 1'b0; pbuf_ra = r_i[PBW-1:0];
        pbuf_we = 1'b0; pbuf_wa = r_len[PBW-1:0];

        case (r_st)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_st      = S_DISP;
                end
            end
            S_DISP: begin
                case (r_cmd.op)
                    mpsm_pkg::OP_ADD: begin
                        if (r_len < LNW'(mpsm_pkg::MAX_LEN)) begin
                            pbuf_we = 1'b1;
                        end
                        if (r_len <= LNW'(mpsm_pkg::MAX_LEN)) begin
                            n_len = r_len + 1'b1;
                        end
                        n_st = S_IDLE;
                    end
                    mpsm_pkg::OP_END: begin
                        n_plen = r_len;
                        n_len  = '0;
                        n_i    = '0;
                        n_cur  = '0;
                        if (r_len == '0) begin
                            n_kind = mpsm_pkg::KIND_EMPTY;
                            n_st   = S_RES;
                        end else if (r_len > LNW'(mpsm_pkg::MAX_LEN)) begin
                            n_kind = mpsm_pkg::KIND_LONG;
                            n_st   = S_RES;
                        end else begin
                            n_st = S_CRD;
                        end
                    end
                    mpsm_pkg::OP_SCAN: begin
                        n_st = S_SCST;
                    end
                    default: begin
                        n_scan = '0;
                        n_st   = S_IDLE;
                    end
                endcase
            end
            // walk existing prefix
            S_CRD: begin
                pbuf_re = 1'b1;
                n_st    = S_CKEY;
            end
            S_CKEY: begin
                n_ksym = pbuf_q;
                n_kpar = r_cur;
                n_sk   = NCW'(1);
                n_sv   = 1'b0;
                n_ret  = S_CCHK;
                n_st   = S_SRCH;
            end
            S_CCHK: begin
                if (r_child != '0) begin
                    n_cur = r_child;
                    n_i   = i_inc;
                    n_st  = (i_inc < r_plen) ? S_CRD : S_CFULL;
                end else begin
                    n_st = S_CFULL;
                end
            end
            S_CFULL: begin
                if (need_sum > (NCW+LNW+1)'(mpsm_pkg::NODES)) begin
                    n_kind = mpsm_pkg::KIND_FULL;
                    n_st   = S_RES;
                end else begin
                    n_st = (r_i < r_plen) ? S_NRD : S_CFIN;
                end
            end
            // append new nodes
            S_NRD: begin
                pbuf_re = 1'b1;
                n_st    = S_NWR;
            end
            S_NWR: begin
                goto_we = 1'b1;
                out_we  = 1'b1;
                n_cur   = r_nc[NW-1:0];
                n_nc    = r_nc + 1'b1;
                n_i     = i_inc;
                n_st    = (i_inc < r_plen) ? S_NRD : S_CFIN;
            end
            S_CFIN: begin
                out_we  = 1'b1;
                out_wa  = r_cur;
                out_wd  = '{vld: 1'b1, id: r_cmd.id};
                n_stale = 1'b1;
                n_kind  = mpsm_pkg::KIND_OK;
                n_st    = S_RES;
            end
            S_RES: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = '{kind: r_kind, id: '0, last: 1'b1};
                    n_st       = S_IDLE;
                end
            end
            // child search, one trie entry per cycle
            S_SRCH: begin
                if (hit) begin
                    n_child = r_sidx;
                    n_sv    = 1'b0;
                    n_st    = r_ret;
                end else if (r_sk < r_nc) begin
                    goto_re = 1'b1;
                    n_sidx  = r_sk[NW-1:0];
                    n_sv    = 1'b1;
                    n_sk    = r_sk + 1'b1;
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_child = '0;
                        n_st    = r_ret;
                    end
                end
            end
            // failure links, one depth level per sweep
            S_RBI: begin
                n_d  = DW'(1);
                n_rv = NCW'(1);
                n_st = S_RBRD;
            end
            S_RBRD: begin
                if (r_rv >= r_nc) begin
                    if (r_d == DW'(mpsm_pkg::MAX_LEN)) begin
                        n_stale = 1'b0;
                        n_st    = S_SCST;
                    end else begin
                        n_d  = r_d + 1'b1;
                        n_rv = NCW'(1);
                    end
                end else begin
                    goto_re = 1'b1;
                    goto_ra = r_rv[NW-1:0];
                    n_st    = S_RBCHK;
                end
            end
            S_RBCHK: begin
                if (goto_q.dep != r_d) begin
                    n_rv = r_rv + 1'b1;
                    n_st = S_RBRD;
                end else begin
                    n_ksym = goto_q.sym;
                    if (goto_q.par == '0) begin
                        fail_we = 1'b1;
                        n_rv    = r_rv + 1'b1;
                        n_st    = S_RBRD;
                    end else begin
                        fail_re = 1'b1;
                        fail_ra = goto_q.par;
                        n_st    = S_RBF;
                    end
                end
            end
            S_RBF: begin
                n_f    = fail_q;
                n_kpar = fail_q;
                n_sk   = NCW'(1);
                n_sv   = 1'b0;
                n_ret  = S_RBS;
                n_st   = S_SRCH;
            end
            S_RBS: begin
                if (r_child != '0 || r_f == '0) begin
                    fail_we = 1'b1;
                    fail_wd = r_child;
                    n_rv    = r_rv + 1'b1;
                    n_st    = S_RBRD;
                end else begin
                    fail_re = 1'b1;
                    fail_ra = r_f;
                    n_st    = S_RBF;
                end
            end
            // text scan
            S_SCST: begin
                if (r_stale) begin
                    n_st = S_RBI;
                end else begin
                    n_scan = scan_base;
                    n_kpar = scan_base;
                    n_ksym = r_cmd.sym;
                    n_sk   = NCW'(1);
                    n_sv   = 1'b0;
                    n_ret  = S_SCS;
                    n_st   = S_SRCH;
                end
            end
            S_SCS: begin
                n_n    = '0;
                n_pend = 1'b0;
                if (r_child != '0) begin
                    n_scan = r_child;
                    n_cv   = r_child;
                    n_st   = S_SCO;
                end else if (r_scan == '0) begin
                    n_st = S_IDLE;
                end else begin
                    fail_re = 1'b1;
                    n_st    = S_SCF;
                end
            end
            S_SCF: begin
                n_scan = fail_q;
                n_kpar = fail_q;
                n_sk   = NCW'(1);
                n_sv   = 1'b0;
                n_ret  = S_SCS;
                n_st   = S_SRCH;
            end
            S_SCO: begin
                if (r_cv == '0 || r_n == RNW'(mpsm_pkg::MAX_RESULTS)) begin
                    n_st = S_SCEND;
                end else begin
                    out_re  = 1'b1;
                    fail_re = 1'b1;
                    fail_ra = r_cv;
                    n_st    = S_SCOQ;
                end
            end
            S_SCOQ: begin
                if (out_q.vld) begin
                    if (!(r_pend && i_res_full)) begin
                        o_res_push = r_pend;
                        n_pid      = out_q.id;
                        n_pend     = 1'b1;
                        n_n        = r_n + 1'b1;
                        n_cv       = fail_q;
                        n_st       = S_SCO;
                    end
                end else begin
                    n_cv = fail_q;
                    n_st = S_SCO;
                end
            end
            S_SCEND: begin
                if (!r_pend) begin
                    n_st = S_IDLE;
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = '{kind: mpsm_pkg::KIND_MATCH, id: r_pid, last: 1'b1};
                    n_pend     = 1'b0;
                    n_st       = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_len   <= '0;
            r_nc    <= NCW'(1);
            r_stale <= 1'b0;
            r_scan  <= '0;
            r_sv    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_len   <= n_len;
            r_nc    <= n_nc;
            r_stale <= n_stale;
            r_scan  <= n_scan;
            r_sv    <= n_sv;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_cmd   <= n_cmd;
        r_plen  <= n_plen;
        r_i     <= n_i;
        r_cur   <= n_cur;
        r_kpar  <= n_kpar;
        r_sk    <= n_sk;
        r_rv    <= n_rv;
        r_kind  <= n_kind;
        r_ksym  <= n_ksym;
        r_sidx  <= n_sidx;
        r_child <= n_child;
        r_f     <= n_f;
        r_cv    <= n_cv;
        r_d     <= n_d;
        r_n     <= n_n;
        r_pid   <= n_pid;
    end

endmodule
